FILE: rtl/osa_pkg.sv
// ----------------------------------------------------------------------------
// osa_pkg
// Shared types and constants of the owner-tagged slot allocator: table size,
// field widths, action codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package osa_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int ACTION_W   = 2;
    localparam int CHANNEL_W  = 7;
    localparam int SLOT_W     = 4;
    localparam int FREED_W    = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RESERVE_ANY = 2'd0,
        ACT_RESERVE_AT  = 2'd1,
        ACT_FIND        = 2'd2,
        ACT_FREE        = 2'd3
    } action_t;

    typedef struct packed {
        logic load;
        logic step;
    } osa_cmd_t;

    typedef struct packed {
        logic scan_last;
    } osa_status_t;

endpackage

FILE: rtl/osa_datapath.sv
// ----------------------------------------------------------------------------
// osa_datapath
// Slot table, request registers and the scan unit that visits one slot per
// cycle, claiming, matching or releasing it according to the held action.
// ----------------------------------------------------------------------------
module osa_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  osa_pkg::osa_cmd_t              cmd,
    output osa_pkg::osa_status_t           status,
    input  osa_pkg::action_t               req_action,
    input  logic [osa_pkg::CHANNEL_W-1:0]  req_channel,
    input  logic [osa_pkg::SLOT_W-1:0]     req_slot_index,
    output logic                           res_success,
    output logic [osa_pkg::SLOT_W-1:0]     res_slot,
    output logic [osa_pkg::FREED_W-1:0]    res_freed
);

    osa_pkg::action_t                  act_reg;
    logic [osa_pkg::CHANNEL_W-1:0]     ch_reg;
    logic [osa_pkg::SLOT_W-1:0]        idx_reg;
    logic [osa_pkg::SLOT_IDX_W-1:0]    cnt_reg;
    logic                              found_reg;
    logic [osa_pkg::SLOT_W-1:0]        slot_reg;
    logic [osa_pkg::FREED_W-1:0]       freed_reg;
    logic [osa_pkg::NUM_SLOTS-1:0]     in_use_reg;
    logic [osa_pkg::CHANNEL_W-1:0]     owner_reg [osa_pkg::NUM_SLOTS];

    logic                              cur_in_use;
    logic                              cur_owned;
    logic [osa_pkg::SLOT_W-1:0]        cur_slot;
    logic                              do_claim;
    logic                              do_hit;
    logic                              do_release;

    always_comb begin
        cur_in_use = in_use_reg[cnt_reg];
        cur_owned  = cur_in_use && (owner_reg[cnt_reg] == ch_reg);
        cur_slot   = osa_pkg::SLOT_W'(cnt_reg);
        do_claim   = 1'b0;
        do_hit     = 1'b0;
        do_release = 1'b0;
        case (act_reg)
            osa_pkg::ACT_RESERVE_ANY: begin
                do_claim = !found_reg && !cur_in_use;
            end
            osa_pkg::ACT_RESERVE_AT: begin
                do_claim = (cur_slot == idx_reg) && !cur_in_use;
            end
            osa_pkg::ACT_FIND: begin
                do_hit = !found_reg && cur_owned;
            end
            osa_pkg::ACT_FREE: begin
                do_release = cur_owned;
            end
            default: begin
                do_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= req_action;
            ch_reg    <= req_channel;
            idx_reg   <= req_slot_index;
            found_reg <= 1'b0;
            slot_reg  <= '0;
            freed_reg <= '0;
        end else if (cmd.step) begin
            if (do_claim) begin
                owner_reg[cnt_reg] <= ch_reg;
            end
            if (do_claim || do_hit) begin
                found_reg <= 1'b1;
                slot_reg  <= cur_slot;
            end
            if (do_release) begin
                found_reg <= 1'b1;
                freed_reg <= freed_reg + osa_pkg::FREED_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            in_use_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg + osa_pkg::SLOT_IDX_W'(1);
            if (do_claim) begin
                in_use_reg[cnt_reg] <= 1'b1;
            end else if (do_release) begin
                in_use_reg[cnt_reg] <= 1'b0;
            end
        end
    end

    assign status.scan_last = (cnt_reg == osa_pkg::SLOT_IDX_W'(osa_pkg::NUM_SLOTS - 1));
    assign res_success      = found_reg;
    assign res_slot         = slot_reg;
    assign res_freed        = freed_reg;

endmodule

FILE: rtl/osa_controller.sv
// ----------------------------------------------------------------------------
// osa_controller
// Sequencer of the allocator: takes a request, steps the datapath across the
// slot table and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module osa_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output osa_pkg::osa_cmd_t     cmd,
    input  osa_pkg::osa_status_t  status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/owner_tagged_slot_allocator.sv
// ----------------------------------------------------------------------------
// owner_tagged_slot_allocator
// Table of buffer slots, each free or owned by a channel. Requests reserve
// the lowest free slot, reserve a named slot, find a channel's lowest slot,
// or release all slots of a channel.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                          Contents
//  request   in         s_tvalid s_tready s_tdata      channel, slot_index
//                       s_tuser                        action
//  result    out        m_tvalid m_tready m_tdata      success, result_slot,
//                                                      freed_count
//
//  A request is taken, then the scan visits one slot per cycle across all
//  NUM_SLOTS slots, then the result is offered; no new request is taken
//  before the result of the last one is out. A new request is taken in the
//  cycle after the result transfer.
//  While m_tready is low the result holds and no request is taken.
//  Reset is synchronous and active low and marks every slot free.
// ----------------------------------------------------------------------------
module owner_tagged_slot_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // channel[6:0], slot_index[10:7], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // success[0], result_slot[4:1],
                                   // freed_count[9:5], zero fill
);

    osa_pkg::osa_cmd_t                 cmd;
    osa_pkg::osa_status_t              status;
    logic                              res_success;
    logic [osa_pkg::SLOT_W-1:0]        res_slot;
    logic [osa_pkg::FREED_W-1:0]       res_freed;

    osa_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    osa_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .req_action     (osa_pkg::action_t'(s_tuser)),
        .req_channel    (s_tdata[6:0]),
        .req_slot_index (s_tdata[10:7]),
        .res_success    (res_success),
        .res_slot       (res_slot),
        .res_freed      (res_freed)
    );

    assign m_tdata = {6'd0, res_freed, res_slot, res_success};

endmodule

FILE: rtl/osa_checker.sv
// ----------------------------------------------------------------------------
// osa_checker
// Port-level checks of the allocator: one request in flight at a time, a
// held result, and consistent result fields. Bound to the top level.
// ----------------------------------------------------------------------------
module osa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic unused_inputs;
    assign unused_inputs = s_tvalid ^ (^s_tdata) ^ (^s_tuser);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while a result is pending");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("request transfer not followed by a scan");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[15:1] == 15'd0))
        else $error("failed result carries nonzero fields");

    a_freed_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[9:5] != 5'd0)) |->
            (m_tdata[0] && (m_tdata[4:1] == 4'd0) &&
             (m_tdata[9:5] <= 5'(osa_pkg::NUM_SLOTS))))
        else $error("free result fields inconsistent");

endmodule

bind owner_tagged_slot_allocator osa_checker u_osa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
